[src/perd_pkg.sv]
// Shared types and constants for the printable-escape run-length decoder.
// Used by perd_ctrl, perd_dp and printable_escape_rle_decoder_top.
`default_nettype none

package perd_pkg;

  localparam int MAX_SYMBOLS = 1024;
  localparam int MAX_RUN     = 64;

  localparam int SYM_W = $clog2(MAX_SYMBOLS + 1);
  localparam int RUN_W = $clog2(MAX_RUN + 1);
  localparam int LEN_W = 17;

  localparam logic [LEN_W-1:0] LEN_LIMIT = 17'h10000;

  localparam logic [7:0] RUN_FLAG   = 8'd33;
  localparam logic [7:0] LOW_FLAG   = 8'd35;
  localparam logic [7:0] MID_FLAG   = 8'd36;
  localparam logic [7:0] HIG_FLAG   = 8'd37;
  localparam logic [7:0] BASE_CODE  = 8'd38;
  localparam logic [7:0] MID_OFFSET = 8'd127;
  localparam logic [7:0] HIG_OFFSET = 8'd200;
  localparam logic [7:0] END_CODE   = 8'd0;

  typedef enum logic [2:0] {
    MODE_START   = 3'd0,
    MODE_COUNT   = 3'd1,
    MODE_BODY    = 3'd2,
    MODE_OFF_LOW = 3'd3,
    MODE_OFF_MID = 3'd4,
    MODE_OFF_HIG = 3'd5
  } mode_t;

  // Controller to datapath
  typedef struct packed {
    logic take_in;   // input transfer this cycle
    logic take_out;  // output transfer this cycle
  } perd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic has_result;  // accepted byte produces at least one result
    logic last_copy;   // pending result is the final one of its group
  } perd_status_t;

endpackage

`default_nettype wire

[src/perd_ctrl.sv]
// Handshake controller of the decoder: receive / transmit state machine.
// Depends on perd_pkg for the command and status structs.
`default_nettype none

module perd_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output perd_pkg::perd_cmd_t        cmd,
  input  wire perd_pkg::perd_status_t status
);
  import perd_pkg::*;

  typedef enum logic {
    S_RX,
    S_TX
  } state_t;

  state_t state;

  assign cmd.take_in  = in_valid && !in_stall;
  assign cmd.take_out = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_RX;
      in_stall  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_RX: begin
          if (cmd.take_in && status.has_result) begin
            state     <= S_TX;
            in_stall  <= 1'b1;
            out_valid <= 1'b1;
          end
        end
        S_TX: begin
          // hold input off until the last copy has gone out
          if (cmd.take_out && status.last_copy) begin
            state     <= S_RX;
            in_stall  <= 1'b0;
            out_valid <= 1'b0;
          end
        end
        default: begin
          state     <= S_RX;
          in_stall  <= 1'b0;
          out_valid <= 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[src/perd_dp.sv]
// Decoder datapath: symbol parsing, run and length counters, result registers.
// Depends on perd_pkg for constants, the mode type and the control structs.
`default_nettype none

module perd_dp (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [7:0]            in_byte,
  input  wire perd_pkg::perd_cmd_t   cmd,
  output perd_pkg::perd_status_t     status,
  output logic [7:0]                 out_byte,
  output logic                       run_last,
  output logic                       frame_end,
  output logic [perd_pkg::LEN_W-1:0] byte_count
);
  import perd_pkg::*;

  // control state
  mode_t            mode;
  logic [RUN_W-1:0] run_len;
  logic [SYM_W-1:0] sym_cnt;
  logic [LEN_W-1:0] dec_len;

  // result registers
  logic [7:0]       out_val;
  logic [RUN_W-1:0] copies;
  logic             fend;
  logic [LEN_W-1:0] bcount;

  mode_t            mode_next;
  logic [RUN_W-1:0] run_len_next;
  logic [SYM_W-1:0] sym_cnt_next;
  logic [LEN_W-1:0] dec_len_next;
  logic             emit;
  logic             term;
  logic [7:0]       emit_val;
  logic [7:0]       count_diff;
  logic [RUN_W-1:0] count_len;
  logic [LEN_W:0]   len_sum;
  logic             flag_hit;
  mode_t            flag_mode;

  always_comb begin
    flag_hit  = 1'b1;
    flag_mode = MODE_START;
    priority if (in_byte == LOW_FLAG) flag_mode = MODE_OFF_LOW;
    else if (in_byte == MID_FLAG)     flag_mode = MODE_OFF_MID;
    else if (in_byte == HIG_FLAG)     flag_mode = MODE_OFF_HIG;
    else                              flag_hit  = 1'b0;
  end

  // count byte to run length, clamped to 1..MAX_RUN
  always_comb begin
    count_diff = in_byte - BASE_CODE;
    priority if (in_byte <= BASE_CODE + 8'd1)
      count_len = RUN_W'(1);
    else if (count_diff > 8'(MAX_RUN))
      count_len = RUN_W'(MAX_RUN);
    else
      count_len = count_diff[RUN_W-1:0];
  end

  always_comb begin
    mode_next    = mode;
    run_len_next = run_len;
    sym_cnt_next = sym_cnt;
    dec_len_next = dec_len;
    emit         = 1'b0;
    term         = 1'b0;
    emit_val     = in_byte;
    len_sum      = {1'b0, dec_len} + (LEN_W + 1)'(run_len);

    unique case (mode)
      MODE_START: begin
        priority if (in_byte == END_CODE) begin
          term = 1'b1;
        end else if (sym_cnt >= SYM_W'(MAX_SYMBOLS)) begin
          // symbol limit reached: drop the byte
        end else if (in_byte == RUN_FLAG) begin
          mode_next = MODE_COUNT;
        end else if (flag_hit) begin
          mode_next = flag_mode;
        end else begin
          emit = 1'b1;
        end
      end
      MODE_COUNT: begin
        run_len_next = count_len;
        mode_next    = MODE_BODY;
      end
      MODE_BODY: begin
        if (flag_hit) mode_next = flag_mode;
        else          emit      = 1'b1;
      end
      MODE_OFF_LOW: begin
        emit     = 1'b1;
        emit_val = in_byte - BASE_CODE;
      end
      MODE_OFF_MID: begin
        emit     = 1'b1;
        emit_val = in_byte + MID_OFFSET;
      end
      MODE_OFF_HIG: begin
        emit     = 1'b1;
        emit_val = in_byte + HIG_OFFSET;
      end
      default: begin
        mode_next    = MODE_START;
        run_len_next = RUN_W'(1);
        sym_cnt_next = '0;
        dec_len_next = '0;
      end
    endcase

    if (emit) begin
      mode_next    = MODE_START;
      run_len_next = RUN_W'(1);
      if (sym_cnt < SYM_W'(MAX_SYMBOLS)) sym_cnt_next = sym_cnt + SYM_W'(1);
      if (len_sum > (LEN_W + 1)'(LEN_LIMIT)) dec_len_next = LEN_LIMIT;
      else                                  dec_len_next = len_sum[LEN_W-1:0];
    end

    if (term) begin
      mode_next    = MODE_START;
      run_len_next = RUN_W'(1);
      sym_cnt_next = '0;
      dec_len_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_START;
      run_len <= RUN_W'(1);
      sym_cnt <= '0;
      dec_len <= '0;
    end else if (cmd.take_in) begin
      mode    <= mode_next;
      run_len <= run_len_next;
      sym_cnt <= sym_cnt_next;
      dec_len <= dec_len_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_in && emit) begin
      out_val <= emit_val;
      copies  <= run_len;
      fend    <= 1'b0;
      bcount  <= '0;
    end else if (cmd.take_in && term) begin
      out_val <= 8'd0;
      copies  <= RUN_W'(1);
      fend    <= 1'b1;
      bcount  <= dec_len;
    end else if (cmd.take_out) begin
      // advance to the next copy of the run
      copies  <= copies - RUN_W'(1);
    end
  end

  assign status.has_result = emit || term;
  assign status.last_copy  = (copies == RUN_W'(1));

  assign out_byte   = out_val;
  assign run_last   = (copies == RUN_W'(1)) && !fend;
  assign frame_end  = fend;
  assign byte_count = bcount;

endmodule

`default_nettype wire

[src/printable_escape_rle_decoder_top.sv]
// Top level of the printable-escape run-length decoder.
// Instantiates perd_ctrl and perd_dp; depends on perd_pkg.
//
//   channel | handshake           | payload
//   --------+---------------------+-------------------------------------------
//   input   | in_valid / in_stall | in_byte
//   output  | out_valid/out_stall | out_byte, run_last, frame_end, byte_count
//
// Each coded byte is taken in on the input handshake. A byte that completes a
// symbol, or a terminator, loads the result registers; the result is then
// sent as 1 to MAX_RUN copies, so a literal symbol gives a single copy.
// Input is stalled while copies of the current symbol are still pending.
// A stall on the output holds the current copy. Reset is synchronous and
// needs no clearing pass; the block accepts input in the cycle after reset.
`default_nettype none

module printable_escape_rle_decoder_top (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [7:0]            in_byte,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [7:0]                 out_byte,
  output logic                       run_last,
  output logic                       frame_end,
  output logic [perd_pkg::LEN_W-1:0] byte_count
);
  import perd_pkg::*;

  perd_cmd_t    cmd;
  perd_status_t status;

  perd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  perd_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .in_byte    (in_byte),
    .cmd        (cmd),
    .status     (status),
    .out_byte   (out_byte),
    .run_last   (run_last),
    .frame_end  (frame_end),
    .byte_count (byte_count)
  );

  a_last_not_end: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(run_last && frame_end))
    else $error("run_last raised on a frame_end result");

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !run_last && !frame_end) |=> out_valid)
    else $error("run ended before its last copy");

  a_group_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && (run_last || frame_end)) |=> (!out_valid && !in_stall))
    else $error("output still pending after final copy");

  a_no_input_while_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !cmd.take_in)
    else $error("input taken while a result is pending");

endmodule

`default_nettype wire
